[hw/rtl/wsd_pkg.sv]
// ----------------------------------------------------------------------------
// WebSocket deframer package
// Shared command type and header constants of the frame deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package wsd_pkg;

	localparam int LEN_W = 63;

	// Seven-bit length codes that announce an extended length field.
	localparam logic [6:0] LEN_CODE_EXT16 = 7'd126;
	localparam logic [6:0] LEN_CODE_EXT64 = 7'd127;

	// Value of the field byte counter on the last byte of each field.
	localparam logic [2:0] EXT16_LAST_CNT = 3'd1;
	localparam logic [2:0] EXT64_LAST_CNT = 3'd7;
	localparam logic [2:0] KEY_LAST_CNT   = 3'd3;

	localparam logic KIND_HEADER  = 1'b0;
	localparam logic KIND_PAYLOAD = 1'b1;

	// One classified request from the parser to the output stage.
	typedef struct packed {
		logic             kind;
		logic             fin;
		logic [3:0]       opcode;
		logic             masked;
		logic [LEN_W-1:0] length;
		logic [7:0]       data;
		logic [7:0]       key_byte;
		logic             last;
	} cmd_t;

endpackage

`default_nettype wire

[hw/rtl/wsd_front.sv]
// ----------------------------------------------------------------------------
// WebSocket deframer parser
// Walks the frame header byte by byte and classifies every payload byte.
// ----------------------------------------------------------------------------
`default_nettype none

module wsd_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	input  wire logic [7:0]    in_byte,
	output      logic          cmd_valid,
	output      wsd_pkg::cmd_t cmd
);

	typedef enum logic [2:0] {
		PH_FIRST   = 3'd0,
		PH_SECOND  = 3'd1,
		PH_EXTLEN  = 3'd2,
		PH_KEY     = 3'd3,
		PH_PAYLOAD = 3'd4
	} phase_t;

	phase_t                    phase_q, phase_d;
	logic [2:0]                cnt_q, cnt_d;
	logic                      fin_q, fin_d;
	logic [3:0]                op_q, op_d;
	logic                      mask_q, mask_d;
	logic                      ext64_q, ext64_d;
	logic [31:0]               key_q, key_d;
	logic [wsd_pkg::LEN_W-1:0] len_q, len_d;
	logic [wsd_pkg::LEN_W-1:0] rem_q, rem_d;
	logic [1:0]                pos_q, pos_d;
	logic                      hdr_done;
	logic                      pay_last;
	logic [7:0]                key_byte;

	always_comb begin
		case (pos_q)
			2'd0:    key_byte = key_q[31:24];
			2'd1:    key_byte = key_q[23:16];
			2'd2:    key_byte = key_q[15:8];
			default: key_byte = key_q[7:0];
		endcase
	end

	assign pay_last = (rem_q <= wsd_pkg::LEN_W'(1));

	always_comb begin
		phase_d   = phase_q;
		cnt_d     = cnt_q;
		fin_d     = fin_q;
		op_d      = op_q;
		mask_d    = mask_q;
		ext64_d   = ext64_q;
		key_d     = key_q;
		len_d     = len_q;
		rem_d     = rem_q;
		pos_d     = pos_q;
		hdr_done  = 1'b0;
		cmd_valid = 1'b0;
		cmd       = '0;

		unique case (phase_q)
			PH_SECOND: begin
				mask_d = in_byte[7];
				key_d  = '0;
				cnt_d  = '0;
				if (in_byte[6:0] == wsd_pkg::LEN_CODE_EXT16) begin
					ext64_d = 1'b0;
					len_d   = '0;
					phase_d = PH_EXTLEN;
				end else if (in_byte[6:0] == wsd_pkg::LEN_CODE_EXT64) begin
					ext64_d = 1'b1;
					len_d   = '0;
					phase_d = PH_EXTLEN;
				end else begin
					len_d = {{(wsd_pkg::LEN_W-7){1'b0}}, in_byte[6:0]};
					if (in_byte[7]) begin
						phase_d = PH_KEY;
					end else begin
						hdr_done = 1'b1;
					end
				end
			end
			PH_EXTLEN: begin
				// The top bit of a 64-bit length falls off the 63-bit register.
				len_d = {len_q[wsd_pkg::LEN_W-9:0], in_byte};
				cnt_d = cnt_q + 3'd1;
				if (cnt_q == (ext64_q ? wsd_pkg::EXT64_LAST_CNT : wsd_pkg::EXT16_LAST_CNT)) begin
					cnt_d = '0;
					if (mask_q) begin
						phase_d = PH_KEY;
					end else begin
						hdr_done = 1'b1;
					end
				end
			end
			PH_KEY: begin
				key_d = {key_q[23:0], in_byte};
				cnt_d = cnt_q + 3'd1;
				if (cnt_q == wsd_pkg::KEY_LAST_CNT) begin
					hdr_done = 1'b1;
				end
			end
			PH_PAYLOAD: begin
				cmd_valid    = 1'b1;
				cmd.kind     = wsd_pkg::KIND_PAYLOAD;
				cmd.fin      = fin_q;
				cmd.opcode   = op_q;
				cmd.masked   = mask_q;
				cmd.length   = len_q;
				cmd.data     = in_byte;
				cmd.key_byte = key_byte;
				cmd.last     = pay_last;
				pos_d        = pos_q + 2'd1;
				if (rem_q != '0) begin
					rem_d = rem_q - wsd_pkg::LEN_W'(1);
				end
				if (pay_last) begin
					phase_d = PH_FIRST;
				end
			end
			default: begin
				// Reserved bits are ignored; undefined phase codes restart here.
				fin_d   = in_byte[7];
				op_d    = in_byte[3:0];
				cnt_d   = '0;
				phase_d = PH_SECOND;
			end
		endcase

		if (hdr_done) begin
			rem_d      = len_d;
			pos_d      = '0;
			cnt_d      = '0;
			phase_d    = (len_d == '0) ? PH_FIRST : PH_PAYLOAD;
			cmd_valid  = 1'b1;
			cmd.kind   = wsd_pkg::KIND_HEADER;
			cmd.fin    = fin_d;
			cmd.opcode = op_d;
			cmd.masked = mask_d;
			cmd.length = len_d;
			cmd.last   = (len_d == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_FIRST;
			cnt_q   <= '0;
			fin_q   <= 1'b0;
			op_q    <= '0;
			mask_q  <= 1'b0;
			ext64_q <= 1'b0;
			key_q   <= '0;
			len_q   <= '0;
			rem_q   <= '0;
			pos_q   <= '0;
		end else if (in_valid) begin
			phase_q <= phase_d;
			cnt_q   <= cnt_d;
			fin_q   <= fin_d;
			op_q    <= op_d;
			mask_q  <= mask_d;
			ext64_q <= ext64_d;
			key_q   <= key_d;
			len_q   <= len_d;
			rem_q   <= rem_d;
			pos_q   <= pos_d;
		end
	end

endmodule

`default_nettype wire

[hw/rtl/wsd_fifo.sv]
// ----------------------------------------------------------------------------
// WebSocket deframer request queue
// Small register queue that decouples the parser from the output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module wsd_fifo #(
	parameter int DEPTH = 4
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          wr_en,
	input  wsd_pkg::cmd_t      wr_data,
	output      logic          full,
	input  wire logic          rd_en,
	output      wsd_pkg::cmd_t rd_data,
	output      logic          empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	wsd_pkg::cmd_t    mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (count_q == FULL_CNT);
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

[hw/rtl/wsd_back.sv]
// ----------------------------------------------------------------------------
// WebSocket deframer output stage
// Unmasks payload requests and holds the oldest result for the consumer.
// ----------------------------------------------------------------------------
`default_nettype none

module wsd_back (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cmd_empty,
	input  wsd_pkg::cmd_t                  cmd,
	output      logic                      cmd_pop,
	output      logic                      empty,
	input  wire logic                      pop,
	output      logic                      item_kind,
	output      logic                      final_fragment,
	output      logic [3:0]                frame_opcode,
	output      logic                      was_masked,
	output      logic [wsd_pkg::LEN_W-1:0] frame_length,
	output      logic [7:0]                payload_byte,
	output      logic                      frame_end
);

	logic valid_q;

	// A new request loads whenever the output register is free or being taken.
	assign cmd_pop = !cmd_empty && (!valid_q || pop);
	assign empty   = !valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd_pop) begin
			valid_q <= 1'b1;
		end else if (pop) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			item_kind      <= cmd.kind;
			final_fragment <= cmd.fin;
			frame_opcode   <= cmd.opcode;
			was_masked     <= cmd.masked;
			frame_length   <= cmd.length;
			payload_byte   <= (cmd.kind == wsd_pkg::KIND_PAYLOAD) ?
				(cmd.data ^ cmd.key_byte) : 8'd0;
			frame_end      <= cmd.last;
		end
	end

endmodule

`default_nettype wire

[hw/rtl/websocket_frame_deframer.sv]
// ----------------------------------------------------------------------------
// WebSocket frame deframer
// Parses a WebSocket frame byte stream and emits headers and unmasked bytes.
// ----------------------------------------------------------------------------
// The block takes one stream byte per clock whenever full is low and can
// deliver one result per clock. Header bytes are absorbed by the parser; when
// the header (including any extended length and masking key) is complete, one
// header result is queued, and each payload byte then yields one result with
// its unmasked value and a last flag. Each request is written into the
// request queue at the edge that accepts its byte, then moves into the
// output register, which drives the output ports, once that register is free
// or being taken. The queue of QUEUE_DEPTH requests lets the parser keep
// taking bytes while the consumer stalls; full rises only once the queue
// and the output register are both occupied.
`default_nettype none

module websocket_frame_deframer #(
	parameter int QUEUE_DEPTH = 4
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output      logic        full,
	input  wire logic [7:0]  stream_byte,
	output      logic        empty,
	input  wire logic        pop,
	output      logic        item_kind,
	output      logic        final_fragment,
	output      logic [3:0]  frame_opcode,
	output      logic        was_masked,
	output      logic [62:0] frame_length,
	output      logic [7:0]  payload_byte,
	output      logic        frame_end
);

	logic          take;
	logic          cmd_valid;
	wsd_pkg::cmd_t cmd_in;
	wsd_pkg::cmd_t cmd_out;
	logic          q_full;
	logic          q_empty;
	logic          q_pop;

	// Each byte makes at most one request, so a free queue slot is enough.
	assign full = q_full;
	assign take = push && !q_full;

	wsd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (take),
		.in_byte   (stream_byte),
		.cmd_valid (cmd_valid),
		.cmd       (cmd_in)
	);

	wsd_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (take && cmd_valid),
		.wr_data (cmd_in),
		.full    (q_full),
		.rd_en   (q_pop),
		.rd_data (cmd_out),
		.empty   (q_empty)
	);

	wsd_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd_empty      (q_empty),
		.cmd            (cmd_out),
		.cmd_pop        (q_pop),
		.empty          (empty),
		.pop            (pop),
		.item_kind      (item_kind),
		.final_fragment (final_fragment),
		.frame_opcode   (frame_opcode),
		.was_masked     (was_masked),
		.frame_length   (frame_length),
		.payload_byte   (payload_byte),
		.frame_end      (frame_end)
	);

endmodule

`default_nettype wire

[tb/sv/tb_websocket_frame_deframer.sv]
// ----------------------------------------------------------------------------
// WebSocket frame deframer testbench
// Streams well-formed frames with random content into the deframer and checks
// every header and unmasked payload result against a cycle-free predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_websocket_frame_deframer;

	typedef enum logic [2:0] {
		ST_BYTE0,
		ST_BYTE1,
		ST_EXTLEN,
		ST_MASKKEY,
		ST_DATA
	} frame_state_t;

	// Length field encodings used when building frames.
	typedef enum int {
		FORM_LEN7,
		FORM_LEN16,
		FORM_LEN64
	} len_form_t;

	typedef struct packed {
		logic                      kind;
		logic                      fin;
		logic [3:0]                opcode;
		logic                      masked;
		logic [wsd_pkg::LEN_W-1:0] length;
		logic [7:0]                data;
		logic                      last;
	} deframe_item_t;

	class deframe_checker;
		frame_state_t    state;
		logic            fin;
		logic [3:0]      opcode;
		logic            masked;
		logic [31:0]     key;
		logic [63:0]     len;
		logic [63:0]     remaining;
		logic [1:0]      key_pos;
		logic [3:0]      field_cnt;
		logic [3:0]      ext_need;
		deframe_item_t   expected_items[$];
		int              errors;

		function new();
			state = ST_BYTE0;
			fin = 1'b0;
			opcode = 4'h0;
			masked = 1'b0;
			key = 32'h0;
			len = 64'h0;
			remaining = 64'h0;
			key_pos = 2'd0;
			field_cnt = 4'd0;
			ext_need = 4'd0;
			errors = 0;
		endfunction

		function deframe_item_t build(logic kind, logic [7:0] data, logic last);
			deframe_item_t item;
			item.kind = kind;
			item.fin = fin;
			item.opcode = opcode;
			item.masked = masked;
			item.length = len[wsd_pkg::LEN_W-1:0];
			item.data = data;
			item.last = last;
			return item;
		endfunction

		function void header_done();
			len[63] = 1'b0;
			remaining = len;
			key_pos = 2'd0;
			field_cnt = 4'd0;
			state = (len == 64'h0) ? ST_BYTE0 : ST_DATA;
			expected_items.push_back(build(wsd_pkg::KIND_HEADER, 8'h00, len == 64'h0));
		endfunction

		function void length_done();
			field_cnt = 4'd0;
			if (masked) begin
				state = ST_MASKKEY;
			end else begin
				header_done();
			end
		endfunction

		function void note_byte(logic [7:0] b);
			logic [7:0] key_byte;
			logic       last;
			case (state)
				ST_BYTE1: begin
					masked = b[7];
					key = 32'h0;
					field_cnt = 4'd0;
					if (b[6:0] == wsd_pkg::LEN_CODE_EXT16) begin
						ext_need = 4'd2;
						len = 64'h0;
						state = ST_EXTLEN;
					end else if (b[6:0] == wsd_pkg::LEN_CODE_EXT64) begin
						ext_need = 4'd8;
						len = 64'h0;
						state = ST_EXTLEN;
					end else begin
						len = {57'h0, b[6:0]};
						length_done();
					end
				end
				ST_EXTLEN: begin
					len = {len[55:0], b};
					field_cnt = field_cnt + 4'd1;
					if (field_cnt >= ext_need)
						length_done();
				end
				ST_MASKKEY: begin
					key = {key[23:0], b};
					field_cnt = field_cnt + 4'd1;
					if (field_cnt >= 4'd4)
						header_done();
				end
				ST_DATA: begin
					// The first key byte sits in the top eight bits of the key.
					key_byte = key[8 * (3 - key_pos) +: 8];
					last = (remaining <= 64'd1);
					expected_items.push_back(build(wsd_pkg::KIND_PAYLOAD, b ^ key_byte,
						last));
					key_pos = key_pos + 2'd1;
					if (remaining != 64'h0)
						remaining = remaining - 64'd1;
					if (last)
						state = ST_BYTE0;
				end
				default: begin
					fin = b[7];
					opcode = b[3:0];
					field_cnt = 4'd0;
					state = ST_BYTE1;
				end
			endcase
		endfunction

		function void report(string field, logic [62:0] want, logic [62:0] got);
			errors++;
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
		endfunction

		function void check_result(deframe_item_t got);
			deframe_item_t want;
			if (expected_items.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none, actual %0h", $time, got);
				return;
			end
			want = expected_items.pop_front();
			if (got.kind !== want.kind)
				report("item_kind", want.kind, got.kind);
			if (got.fin !== want.fin)
				report("final_fragment", want.fin, got.fin);
			if (got.opcode !== want.opcode)
				report("frame_opcode", want.opcode, got.opcode);
			if (got.masked !== want.masked)
				report("was_masked", want.masked, got.masked);
			if (got.length !== want.length)
				report("frame_length", want.length, got.length);
			if (got.data !== want.data)
				report("payload_byte", want.data, got.data);
			if (got.last !== want.last)
				report("frame_end", want.last, got.last);
		endfunction

		function int pending();
			return expected_items.size();
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        full;
	logic [7:0]  stream_byte = 8'h00;
	logic        empty;
	logic        pop = 1'b0;
	logic        item_kind;
	logic        final_fragment;
	logic [3:0]  frame_opcode;
	logic        was_masked;
	logic [62:0] frame_length;
	logic [7:0]  payload_byte;
	logic        frame_end;

	deframe_checker chk;
	deframe_item_t  got;
	int             send_idle_pct;
	int             recv_idle_pct;
	int             bytes_accepted;

	websocket_frame_deframer DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (push),
		.full           (full),
		.stream_byte    (stream_byte),
		.empty          (empty),
		.pop            (pop),
		.item_kind      (item_kind),
		.final_fragment (final_fragment),
		.frame_opcode   (frame_opcode),
		.was_masked     (was_masked),
		.frame_length   (frame_length),
		.payload_byte   (payload_byte),
		.frame_end      (frame_end)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("websocket_frame_deframer regression: fail");
		$finish;
	end

	// Outputs are sampled right after the edge, before the block updates them.
	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(99) < send_idle_pct) begin
			push = 1'b0;
			@(negedge clk);
		end
		push = 1'b1;
		stream_byte = b;
		do @(posedge clk); while (full);
		chk.note_byte(b);
		bytes_accepted++;
		@(negedge clk);
	endtask

	task automatic send_frame(input logic fin, input logic [2:0] rsv, input logic [3:0] opc,
			input logic masked, input len_form_t form, input logic [63:0] len,
			input int n_bytes);
		logic [31:0] key;
		logic [6:0]  code;
		key = $urandom;
		case (form)
			FORM_LEN16: code = wsd_pkg::LEN_CODE_EXT16;
			FORM_LEN64: code = wsd_pkg::LEN_CODE_EXT64;
			default:    code = len[6:0];
		endcase
		send_byte({fin, rsv, opc});
		send_byte({masked, code});
		if (form == FORM_LEN16) begin
			send_byte(len[15:8]);
			send_byte(len[7:0]);
		end else if (form == FORM_LEN64) begin
			for (int i = 7; i >= 0; i--)
				send_byte(len[8 * i +: 8]);
		end
		if (masked) begin
			for (int i = 3; i >= 0; i--)
				send_byte(key[8 * i +: 8]);
		end
		for (int i = 0; i < n_bytes; i++)
			send_byte(8'($urandom_range(255)));
	endtask

	task automatic rand_frame();
		int          r;
		logic [63:0] len;
		len_form_t   form;
		r = $urandom_range(99);
		if (r < 62) begin
			form = FORM_LEN7;
			len = 64'($urandom_range(12));
		end else if (r < 66) begin
			form = FORM_LEN7;
			len = 64'($urandom_range(125, 100));
		end else if (r < 84) begin
			// Short lengths in the 16-bit field are not minimal but still legal.
			form = FORM_LEN16;
			len = 64'($urandom_range(20));
		end else if (r < 87) begin
			form = FORM_LEN16;
			len = 64'($urandom_range(300, 126));
		end else begin
			// The top length bit is dropped by the block, so it may be set freely.
			form = FORM_LEN64;
			len = {1'($urandom_range(1)), 58'h0, 5'($urandom_range(20))};
		end
		send_frame(1'($urandom_range(1)), 3'($urandom_range(7)), 4'($urandom_range(15)),
			1'($urandom_range(1)), form, len, int'(len[62:0]));
	endtask

	task automatic run_random(input int budget);
		int start;
		start = bytes_accepted;
		while (bytes_accepted - start < budget)
			rand_frame();
	endtask

	initial begin
		chk = new();
		bytes_accepted = 0;
		send_idle_pct = 30;
		recv_idle_pct = 49;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		fork
			forever begin
				@(negedge clk);
				pop = ($urandom_range(99) >= recv_idle_pct);
				@(posedge clk);
				if (pop && !empty) begin
					got.kind = item_kind;
					got.fin = final_fragment;
					got.opcode = frame_opcode;
					got.masked = was_masked;
					got.length = frame_length;
					got.data = payload_byte;
					got.last = frame_end;
					chk.check_result(got);
				end
			end
		join_none

		// Empty masked frame with all reserved bits set and the top opcode.
		send_frame(1'b1, 3'b111, 4'hf, 1'b1, FORM_LEN7, 64'd0, 0);
		send_frame(1'b0, 3'b000, 4'h0, 1'b0, FORM_LEN7, 64'd1, 1);
		send_frame(1'b1, 3'b101, 4'h1, 1'b1, FORM_LEN16, 64'd3, 3);
		send_frame(1'b0, 3'b010, 4'h2, 1'b0, FORM_LEN64, 64'h8000_0000_0000_0002, 2);

		run_random(310);
		send_idle_pct = 49;
		recv_idle_pct = 30;
		run_random(310);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		run_random(310);

		// A maximal length can never finish, so it closes the stream.
		send_frame(1'b1, 3'b000, 4'h9, 1'b1, FORM_LEN64, 64'hffff_ffff_ffff_ffff, 6);
		push = 1'b0;

		while (chk.pending() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
		if (chk.errors == 0)
			$display("websocket_frame_deframer regression: pass");
		else
			$display("websocket_frame_deframer regression: fail");
		$finish;
	end
endmodule
